FILE: hdl/jdz_pkg.sv
// Shared types, constants and constant functions for the joystick dead zone block.
package jdz_pkg;

  localparam int unsigned FracBits  = 14;
  localparam int unsigned SampleW   = 16;
  localparam int unsigned NW        = FracBits + 1;
  localparam int unsigned One       = 1 << FracBits;
  localparam int unsigned DzW       = 13;
  localparam int unsigned DzMax     = (3 * One) / 10;
  localparam int unsigned DzReset   = (3 * One + 10) / 20;
  localparam int unsigned ModeW     = 2;
  localparam int unsigned ExpW      = 11;
  localparam int unsigned ExpMin    = 256;
  localparam int unsigned ExpMax    = 1280;
  localparam int unsigned ExpReset  = 512;
  localparam int unsigned SqSteps   = 16;
  localparam int unsigned RescaleQW = 17;
  localparam int unsigned WQ        = 30;
  localparam int unsigned LogSteps  = 20;
  localparam int unsigned DivQW     = 24;
  localparam int unsigned CrvDepth  = 1 + LogSteps + 2 + DivQW + 1 + LogSteps + 1;
  localparam int unsigned OutQW     = FracBits + 1;

  localparam logic [ModeW-1:0] ModeLinear = 2'd0;
  localparam logic [ModeW-1:0] ModePower  = 2'd1;
  localparam logic [ModeW-1:0] ModeLog    = 2'd2;

  localparam logic [1:0] RegDeadZone = 2'd0;
  localparam logic [1:0] RegCurveMode = 2'd1;
  localparam logic [1:0] RegCurveExp = 2'd2;

  typedef struct packed {
    logic signed [SampleW-1:0] x_in;
    logic signed [SampleW-1:0] y_in;
  } sample_in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] x_out;
    logic signed [SampleW-1:0] y_out;
  } sample_out_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] rem;
    logic [63:0] bit_v;
    res   = '0;
    rem   = v;
    bit_v = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bit_v) begin
        rem = rem - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // 2^(-2^-k) in Q30
  function automatic logic [WQ-1:0] exp_step(input int k);
    logic [63:0] s;
    s = isqrt64(64'd1 << 59);
    for (int i = 2; i <= LogSteps; i++) begin
      if (i <= k) s = isqrt64(s << WQ);
    end
    return s[WQ-1:0];
  endfunction

endpackage

FILE: hdl/joystick_deadzone_response_curve.sv
// Top level: radial dead zone, rescale and response curve on stick samples.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------
//  input    | in_valid_i / in_stall_o   | in_data_i  (x_in, y_in)
//  output   | out_valid_o / out_stall_i | out_data_o (x_out, y_out)
//  config   | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// One transfer per cycle while the output is not stalled; the pipeline is 2 stage squares,
// 16 stage square root, 18 stage rescale divider, 69 stage curve, 16 stage
// output divider and an output register.
// Reset clears valid bits and loads register defaults.
// A stalled output freezes the whole pipeline; in_stall_o follows it.
module joystick_deadzone_response_curve (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  jdz_pkg::sample_in_t    in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output jdz_pkg::sample_out_t   out_data_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import jdz_pkg::*;

  typedef struct packed {
    logic signed [SampleW-1:0] x;
    logic signed [SampleW-1:0] y;
  } xy_t;

  typedef struct packed {
    xy_t         xy;
    logic [31:0] xx;
    logic [31:0] yy;
  } sqr_t;

  typedef struct packed {
    xy_t         xy;
    logic [31:0] rad;
    logic [17:0] rem;
    logic [15:0] root;
  } sq_t;

  typedef struct packed {
    xy_t                  xy;
    logic [15:0]          m;
    logic                 zero;
    logic [NW-1:0]        dvs;
    logic [NW-1:0]        rem;
    logic [RescaleQW-1:0] lo;
    logic [RescaleQW-1:0] q;
  } dv_t;

  typedef struct packed {
    xy_t         xy;
    logic [15:0] m;
    logic        zero;
  } side_t;

  typedef struct packed {
    logic [15:0]      rem;
    logic [OutQW-1:0] lo;
    logic [OutQW-1:0] q;
  } axis_t;

  typedef struct packed {
    logic        negx;
    logic        negy;
    logic        zero;
    logic [15:0] m;
    axis_t       ax;
    axis_t       ay;
  } od_t;

  function automatic axis_t axis_step(input axis_t a, input logic [15:0] m);
    logic [16:0] rn;
    logic        ge;
    axis_t       r;
    rn = {a.rem, a.lo[OutQW-1]};
    ge = (rn >= {1'b0, m});
    r.rem = ge ? 16'(rn - {1'b0, m}) : rn[15:0];
    r.lo  = {a.lo[OutQW-2:0], 1'b0};
    r.q   = {a.q[OutQW-2:0], ge};
    return r;
  endfunction

  function automatic axis_t axis_init(input logic signed [SampleW-1:0] v,
                                      input logic [NW-1:0] c);
    logic [16:0] av;
    logic [31:0] prod;
    axis_t       r;
    av   = v[SampleW-1] ? 17'(17'd0 - {v[SampleW-1], v}) : {1'b0, v};
    prod = 32'(av) * 32'(c);
    r.rem = prod[30:15];
    r.lo  = prod[OutQW-1:0];
    r.q   = '0;
    return r;
  endfunction

  // configuration
  logic [DzW-1:0]   dz_q;
  logic [ModeW-1:0] mode_q;
  logic [ExpW-1:0]  exp_q;
  logic             cfg_wr;
  logic [DzW-1:0]   dz_wr;
  logic [ExpW-1:0]  exp_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign dz_wr  = (pwdata[DzW-1:0] > DzW'(DzMax)) ? DzW'(DzMax) : pwdata[DzW-1:0];
  assign exp_wr = (pwdata[ExpW-1:0] < ExpW'(ExpMin)) ? ExpW'(ExpMin) :
                  (pwdata[ExpW-1:0] > ExpW'(ExpMax)) ? ExpW'(ExpMax) :
                  pwdata[ExpW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q   <= DzW'(DzReset);
      mode_q <= ModeLinear;
      exp_q  <= ExpW'(ExpReset);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegDeadZone:  dz_q   <= dz_wr;
        RegCurveMode: mode_q <= pwdata[ModeW-1:0];
        RegCurveExp:  exp_q  <= exp_wr;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegDeadZone:  prdata = 32'(dz_q);
      RegCurveMode: prdata = 32'(mode_q);
      RegCurveExp:  prdata = 32'(exp_q);
      default:      prdata = '0;
    endcase
  end

  // pipeline control
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // squares and sum
  sqr_t        s0_q, s0_d;
  logic        s0_vld_q;
  xy_t         s1_xy_q;
  logic [31:0] s1_sum_q;
  logic        s1_vld_q;

  always_comb begin
    logic signed [31:0] px;
    logic signed [31:0] py;
    px = in_data_i.x_in * in_data_i.x_in;
    py = in_data_i.y_in * in_data_i.y_in;
    s0_d.xy.x = in_data_i.x_in;
    s0_d.xy.y = in_data_i.y_in;
    s0_d.xx   = unsigned'(px);
    s0_d.yy   = unsigned'(py);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= in_valid_i;
      s1_vld_q <= s0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q     <= s0_d;
      s1_xy_q  <= s0_q.xy;
      s1_sum_q <= s0_q.xx + s0_q.yy;
    end
  end

  // square root, one result bit per stage
  sq_t                sq_q [SqSteps];
  logic [SqSteps-1:0] sq_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= '0;
    end else if (en) begin
      sq_vld_q <= {sq_vld_q[SqSteps-2:0], s1_vld_q};
    end
  end

  for (genvar i = 0; i < SqSteps; i++) begin : g_sq
    sq_t prev;
    sq_t sq_d;
    if (i == 0) begin : g_first
      always_comb begin
        prev.xy   = s1_xy_q;
        prev.rad  = s1_sum_q;
        prev.rem  = '0;
        prev.root = '0;
      end
    end else begin : g_next
      assign prev = sq_q[i-1];
    end

    always_comb begin
      logic [19:0] rn;
      logic [19:0] t;
      sq_d = prev;
      rn   = {prev.rem, prev.rad[31-2*i -: 2]};
      t    = {2'b00, prev.root, 2'b01};
      if (rn >= t) begin
        sq_d.rem  = 18'(rn - t);
        sq_d.root = {prev.root[14:0], 1'b1};
      end else begin
        sq_d.rem  = rn[17:0];
        sq_d.root = {prev.root[14:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) sq_q[i] <= sq_d;
    end
  end

  // dead zone and rescale divider
  localparam int unsigned DvStages = RescaleQW + 1;
  dv_t                 dv_q [DvStages];
  logic [DvStages-1:0] dv_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q <= '0;
    end else if (en) begin
      dv_vld_q <= {dv_vld_q[DvStages-2:0], sq_vld_q[SqSteps-1]};
    end
  end

  for (genvar j = 0; j < DvStages; j++) begin : g_dv
    dv_t dv_d;
    if (j == 0) begin : g_init
      always_comb begin
        logic [15:0] m;
        logic [15:0] diff;
        m         = sq_q[SqSteps-1].root;
        diff      = m - 16'(dz_q);
        dv_d.xy   = sq_q[SqSteps-1].xy;
        dv_d.m    = m;
        dv_d.zero = (m < 16'(dz_q)) || (m == '0);
        dv_d.dvs  = NW'(One) - NW'(dz_q);
        dv_d.rem  = NW'(diff >> (RescaleQW - FracBits));
        dv_d.lo   = {diff[RescaleQW-FracBits-1:0], {FracBits{1'b0}}};
        dv_d.q    = '0;
      end
    end else begin : g_step
      always_comb begin
        logic [NW:0] rn;
        logic        ge;
        dv_d = dv_q[j-1];
        rn   = {dv_q[j-1].rem, dv_q[j-1].lo[RescaleQW-1]};
        ge   = (rn >= {1'b0, dv_q[j-1].dvs});
        dv_d.rem = ge ? NW'(rn - {1'b0, dv_q[j-1].dvs}) : rn[NW-1:0];
        dv_d.lo  = {dv_q[j-1].lo[RescaleQW-2:0], 1'b0};
        dv_d.q   = {dv_q[j-1].q[RescaleQW-2:0], ge};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) dv_q[j] <= dv_d;
    end
  end

  // clamp and curve
  logic [NW-1:0] n_clamp;
  side_t         side_d;
  logic          crv_vld;
  logic [NW-1:0] crv_c;

  always_comb begin
    dv_t l;
    l       = dv_q[DvStages-1];
    n_clamp = (l.q > RescaleQW'(One)) ? NW'(One) : l.q[NW-1:0];
    side_d.xy   = l.xy;
    side_d.m    = l.m;
    side_d.zero = l.zero || (n_clamp == '0);
  end

  jdz_curve u_curve (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (dv_vld_q[DvStages-1]),
    .n_i        (n_clamp),
    .mode_i     (mode_q),
    .exponent_i (exp_q),
    .valid_o    (crv_vld),
    .c_o        (crv_c)
  );

  side_t side_q [CrvDepth];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      for (int k = 1; k < CrvDepth; k++) side_q[k] <= side_q[k-1];
    end
  end

  // output scaling: |v| * c / m per axis
  localparam int unsigned OdStages = OutQW + 1;
  od_t                 od_q [OdStages];
  logic [OdStages-1:0] od_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      od_vld_q <= '0;
    end else if (en) begin
      od_vld_q <= {od_vld_q[OdStages-2:0], crv_vld};
    end
  end

  for (genvar j = 0; j < OdStages; j++) begin : g_od
    od_t od_d;
    if (j == 0) begin : g_init
      always_comb begin
        side_t sd;
        sd        = side_q[CrvDepth-1];
        od_d.negx = sd.xy.x[SampleW-1];
        od_d.negy = sd.xy.y[SampleW-1];
        od_d.zero = sd.zero;
        od_d.m    = sd.m;
        od_d.ax   = axis_init(sd.xy.x, crv_c);
        od_d.ay   = axis_init(sd.xy.y, crv_c);
      end
    end else begin : g_step
      always_comb begin
        od_d    = od_q[j-1];
        od_d.ax = axis_step(od_q[j-1].ax, od_q[j-1].m);
        od_d.ay = axis_step(od_q[j-1].ay, od_q[j-1].m);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) od_q[j] <= od_d;
    end
  end

  // output register
  sample_out_t out_q, out_d;
  logic        out_vld_q;

  always_comb begin
    od_t l;
    logic [SampleW-1:0] qx;
    logic [SampleW-1:0] qy;
    l  = od_q[OdStages-1];
    qx = SampleW'(l.ax.q);
    qy = SampleW'(l.ay.q);
    out_d.x_out = l.zero ? '0 : (l.negx ? signed'(SampleW'(0) - qx) : signed'(qx));
    out_d.y_out = l.zero ? '0 : (l.negy ? signed'(SampleW'(0) - qy) : signed'(qy));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= od_vld_q[OdStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

FILE: hdl/jdz_curve.sv
// Response curve pipeline: log2, multiply or divide by the exponent, and exp2 in fixed point.
module jdz_curve (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [jdz_pkg::NW-1:0]      n_i,
  input  logic [jdz_pkg::ModeW-1:0]   mode_i,
  input  logic [jdz_pkg::ExpW-1:0]    exponent_i,
  output logic                        valid_o,
  output logic [jdz_pkg::NW-1:0]      c_o
);
  import jdz_pkg::*;

  localparam int unsigned StLog = 1;
  localparam int unsigned StL   = StLog + LogSteps;
  localparam int unsigned StMul = StL + 1;
  localparam int unsigned StDiv = StMul + 1;
  localparam int unsigned StSel = StDiv + DivQW;
  localparam int unsigned StExp = StSel + 1;
  localparam int unsigned StFin = StExp + LogSteps;

  typedef struct packed {
    logic              pw;
    logic              inv;
    logic [NW-1:0]     c;
    logic [3:0]        k;
    logic [WQ:0]       mant;
    logic [LogSteps-1:0] frac;
    logic [23:0]       l;
    logic [26:0]       amul;
    logic [ExpW-1:0]   rem;
    logic [DivQW-1:0]  lo;
    logic [DivQW-1:0]  q;
    logic [26:0]       a;
    logic [WQ:0]       r;
  } crv_t;

  crv_t              st_q [CrvDepth];
  logic [CrvDepth-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[CrvDepth-2:0], valid_i};
    end
  end

  for (genvar s = 0; s < CrvDepth; s++) begin : g_st
    crv_t st_d;
    if (s == 0) begin : g_prep
      always_comb begin
        logic [NW-1:0] w;
        logic [NW-1:0] ws;
        st_d = '0;
        st_d.pw  = (mode_i == ModePower) ||
                   ((mode_i == ModeLog) && (n_i != NW'(One)));
        st_d.inv = (mode_i == ModeLog);
        w        = (mode_i == ModeLog) ? NW'(One) - n_i : n_i;
        st_d.c   = (mode_i == ModeLog) ? NW'(One) : n_i;
        for (int b = 0; b < NW; b++) begin
          if (w[b]) st_d.k = 4'(NW - 1 - b);
        end
        ws = w << st_d.k;
        st_d.mant = {ws, {(WQ - FracBits){1'b0}}};
      end
    end else if (s < StL) begin : g_log
      always_comb begin
        logic [2*WQ+1:0] prod;
        logic [WQ+1:0]   mt;
        st_d = st_q[s-1];
        prod = st_q[s-1].mant * st_q[s-1].mant;
        mt   = prod[2*WQ+1:WQ];
        if (mt[WQ+1]) begin
          st_d.mant = mt[WQ+1:1];
          st_d.frac = {st_q[s-1].frac[LogSteps-2:0], 1'b1};
        end else begin
          st_d.mant = mt[WQ:0];
          st_d.frac = {st_q[s-1].frac[LogSteps-2:0], 1'b0};
        end
      end
    end else if (s == StL) begin : g_l
      always_comb begin
        st_d = st_q[s-1];
        st_d.l = {st_q[s-1].k, {LogSteps{1'b0}}} - 24'(st_q[s-1].frac);
      end
    end else if (s == StMul) begin : g_mul
      always_comb begin
        logic [34:0] lp;
        st_d = st_q[s-1];
        lp   = 35'(st_q[s-1].l) * 35'(exponent_i);
        st_d.amul = lp[34:8];
        st_d.rem  = ExpW'(st_q[s-1].l[23:16]);
        st_d.lo   = {st_q[s-1].l[15:0], 8'd0};
        st_d.q    = '0;
      end
    end else if (s < StSel) begin : g_div
      always_comb begin
        logic [ExpW:0] rn;
        logic          ge;
        st_d = st_q[s-1];
        rn   = {st_q[s-1].rem, st_q[s-1].lo[DivQW-1]};
        ge   = (rn >= {1'b0, exponent_i});
        st_d.rem = ge ? ExpW'(rn - {1'b0, exponent_i}) : rn[ExpW-1:0];
        st_d.lo  = {st_q[s-1].lo[DivQW-2:0], 1'b0};
        st_d.q   = {st_q[s-1].q[DivQW-2:0], ge};
      end
    end else if (s == StSel) begin : g_sel
      always_comb begin
        st_d = st_q[s-1];
        st_d.a = st_q[s-1].inv ? 27'(st_q[s-1].q) : st_q[s-1].amul;
        st_d.r = (WQ+1)'(1) << WQ;
      end
    end else if (s < StFin) begin : g_exp
      localparam logic [WQ-1:0] Step = exp_step(s - StSel);
      always_comb begin
        logic [2*WQ:0] prod;
        st_d = st_q[s-1];
        prod = (2*WQ+1)'(st_q[s-1].r) * (2*WQ+1)'(Step);
        if (st_q[s-1].a[LogSteps - (s - StSel)]) st_d.r = prod[2*WQ:WQ];
      end
    end else begin : g_fin
      always_comb begin
        logic [6:0]  ip;
        logic [WQ:0] sr;
        logic [NW-1:0] res;
        st_d = st_q[s-1];
        ip   = st_q[s-1].a[26:20];
        sr   = st_q[s-1].r >> (5'(ip[3:0]) + 5'(WQ - FracBits));
        res  = (ip >= 7'(NW)) ? '0 : sr[NW-1:0];
        if (st_q[s-1].pw) begin
          st_d.c = st_q[s-1].inv ? NW'(One) - res : res;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) st_q[s] <= st_d;
    end
  end

  assign valid_o = vld_q[CrvDepth-1];
  assign c_o     = st_q[CrvDepth-1].c;

endmodule
